// ===== design/sddc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and date helpers for the serial day date calculator.
// No dependencies; every other design file uses this package.
package sddc_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned SerialW = 22;
  localparam int unsigned CountW  = 22;
  localparam int unsigned DayW    = 5;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DoyW    = 9;
  localparam int unsigned DowW    = 3;

  localparam int unsigned FirstYear   = 1901;
  localparam int unsigned LastYear    = 9999;
  localparam int unsigned LeapsTo1900 = 1900 / 4 - 1900 / 100 + 1900 / 400;
  // Serial number of 31 Dec of the last year
  localparam int unsigned LastSerial  = 365 * (LastYear - 1900) + LastYear / 4
                                        - LastYear / 100 + LastYear / 400 - LeapsTo1900;

  // ceil(2^34 / 1461): exact quotient of 4*(n-1) / 1461 for 24-bit dividends
  localparam int unsigned RecipYearMul   = 11758980;
  localparam int unsigned RecipYearShift = 34;
  // ceil(2^19 / 100): exact quotient of y / 100 for 14-bit y
  localparam int unsigned RecipHundred      = 5243;
  localparam int unsigned RecipHundredShift = 19;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_SUB  = 2'd2
  } sddc_cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CMD,
    ST_EST,
    ST_LEAP,
    ST_DBY_A,
    ST_DBY_B,
    ST_YWALK,
    ST_WLEAP,
    ST_MSTART,
    ST_MWALK,
    ST_LOAD,
    ST_FIN
  } sddc_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CMD,
    OP_EST,
    OP_LEAP,
    OP_DBY_A,
    OP_DBY_B,
    OP_YSTEP,
    OP_MSTART,
    OP_MSTEP,
    OP_LOAD,
    OP_FIN
  } sddc_op_e;

  typedef struct packed {
    logic     latch;
    sddc_op_e op;
  } sddc_ctrl_t;

  typedef struct packed {
    logic go_load;
    logic go_walk;
    logic ystep;
    logic mstep;
    logic out_free;
  } sddc_stat_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [DayW-1:0]   load_day;
    logic [MonthW-1:0] load_month;
    logic [YearW-1:0]  load_year;
    logic [CountW-1:0] day_count;
  } sddc_req_t;

  function automatic logic is_leap(input logic [YearW-1:0] year);
    logic [26:0]      prod;
    logic [7:0]       quo;
    logic [YearW-1:0] rem;
    prod = 27'(year) * 27'(RecipHundred);
    quo  = prod[26:RecipHundredShift];
    rem  = year - YearW'(YearW'(quo) * YearW'(100));
    return (year[1:0] == 2'b00) && ((rem != '0) || (quo[1:0] == 2'b00));
  endfunction

  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] month,
                                                 input logic leap);
    logic [DayW-1:0] len;
    case (month)
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // Days before the first of the month in a common year
  function automatic logic [DoyW-1:0] days_before_month(input logic [MonthW-1:0] month);
    logic [DoyW-1:0] cum;
    case (month)
      4'd2:    cum = 9'd31;
      4'd3:    cum = 9'd59;
      4'd4:    cum = 9'd90;
      4'd5:    cum = 9'd120;
      4'd6:    cum = 9'd151;
      4'd7:    cum = 9'd181;
      4'd8:    cum = 9'd212;
      4'd9:    cum = 9'd243;
      4'd10:   cum = 9'd273;
      4'd11:   cum = 9'd304;
      4'd12:   cum = 9'd334;
      default: cum = 9'd0;
    endcase
    return cum;
  endfunction

  // n mod 7 by folding octal digits, since 8 = 1 mod 7
  function automatic logic [DowW-1:0] mod7(input logic [SerialW-1:0] n);
    logic [23:0] w;
    logic [5:0]  s1;
    logic [3:0]  s2;
    logic [2:0]  s3;
    w  = {2'b00, n};
    s1 = '0;
    for (int i = 0; i < 8; i++) begin
      s1 = s1 + 6'(w[3*i +: 3]);
    end
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    s3 = s2[2:0] + 3'(s2[3]);
    return (s3 == 3'd7) ? 3'd0 : s3;
  endfunction

  // 1 Sunday .. 7 Saturday; serial 1 was a Tuesday
  function automatic logic [DowW-1:0] weekday_of(input logic [SerialW-1:0] n);
    logic [DowW-1:0] r;
    r = mod7(n);
    return (r == 3'd6) ? 3'd1 : r + 3'd2;
  endfunction

endpackage

// ===== design/sddc_if.sv =====
`timescale 1ns / 1ps
// Request and result channel interfaces with valid/ready handshake.
// Depends on sddc_pkg for field widths.
interface sddc_req_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     command;
  logic [sddc_pkg::DayW-1:0]      load_day;
  logic [sddc_pkg::MonthW-1:0]    load_month;
  logic [sddc_pkg::YearW-1:0]     load_year;
  logic [sddc_pkg::CountW-1:0]    day_count;

  modport source (output valid, command, load_day, load_month, load_year, day_count,
                  input ready);
  modport sink (input valid, command, load_day, load_month, load_year, day_count,
                output ready);
endinterface

interface sddc_res_if;
  logic                           valid;
  logic                           ready;
  logic                           valid_res;
  logic [sddc_pkg::DayW-1:0]      day_of_month;
  logic [sddc_pkg::MonthW-1:0]    month_number;
  logic [sddc_pkg::YearW-1:0]     year_number;
  logic [sddc_pkg::SerialW-1:0]   serial_day;
  logic [sddc_pkg::DowW-1:0]      weekday;
  logic                           leap;

  modport source (output valid, valid_res, day_of_month, month_number, year_number,
                  serial_day, weekday, leap, input ready);
  modport sink (input valid, valid_res, day_of_month, month_number, year_number,
                serial_day, weekday, leap, output ready);
endinterface

// ===== design/sddc_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: sequences load, year walk and month walk steps.
// Depends on sddc_pkg; drives the datapath through sddc_ctrl_t.
module sddc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  sddc_pkg::sddc_stat_t stat_i,
  output sddc_pkg::sddc_ctrl_t ctrl_o
);

  sddc_pkg::sddc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sddc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sddc_pkg::ST_IDLE: begin
        if (req_valid_i) state_d = sddc_pkg::ST_CMD;
      end
      sddc_pkg::ST_CMD: begin
        if (stat_i.go_load) begin
          state_d = sddc_pkg::ST_LEAP;
        end else if (stat_i.go_walk) begin
          state_d = sddc_pkg::ST_EST;
        end else begin
          state_d = sddc_pkg::ST_FIN;
        end
      end
      sddc_pkg::ST_EST:   state_d = sddc_pkg::ST_LEAP;
      sddc_pkg::ST_LEAP:  state_d = sddc_pkg::ST_DBY_A;
      sddc_pkg::ST_DBY_A: state_d = sddc_pkg::ST_DBY_B;
      sddc_pkg::ST_DBY_B: begin
        state_d = stat_i.go_load ? sddc_pkg::ST_LOAD : sddc_pkg::ST_YWALK;
      end
      sddc_pkg::ST_YWALK: begin
        state_d = stat_i.ystep ? sddc_pkg::ST_WLEAP : sddc_pkg::ST_MSTART;
      end
      sddc_pkg::ST_WLEAP:  state_d = sddc_pkg::ST_YWALK;
      sddc_pkg::ST_MSTART: state_d = sddc_pkg::ST_MWALK;
      sddc_pkg::ST_MWALK: begin
        if (!stat_i.mstep) state_d = sddc_pkg::ST_FIN;
      end
      sddc_pkg::ST_LOAD: state_d = sddc_pkg::ST_FIN;
      sddc_pkg::ST_FIN: begin
        if (stat_i.out_free) state_d = sddc_pkg::ST_IDLE;
      end
      default: state_d = sddc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o  = 1'b0;
    ctrl_o.latch = 1'b0;
    ctrl_o.op    = sddc_pkg::OP_NONE;
    unique case (state_q)
      sddc_pkg::ST_IDLE: begin
        req_ready_o  = 1'b1;
        ctrl_o.latch = req_valid_i;
      end
      sddc_pkg::ST_CMD:    ctrl_o.op = sddc_pkg::OP_CMD;
      sddc_pkg::ST_EST:    ctrl_o.op = sddc_pkg::OP_EST;
      sddc_pkg::ST_LEAP,
      sddc_pkg::ST_WLEAP:  ctrl_o.op = sddc_pkg::OP_LEAP;
      sddc_pkg::ST_DBY_A:  ctrl_o.op = sddc_pkg::OP_DBY_A;
      sddc_pkg::ST_DBY_B:  ctrl_o.op = sddc_pkg::OP_DBY_B;
      sddc_pkg::ST_YWALK:  ctrl_o.op = sddc_pkg::OP_YSTEP;
      sddc_pkg::ST_MSTART: ctrl_o.op = sddc_pkg::OP_MSTART;
      sddc_pkg::ST_MWALK:  ctrl_o.op = sddc_pkg::OP_MSTEP;
      sddc_pkg::ST_LOAD:   ctrl_o.op = sddc_pkg::OP_LOAD;
      sddc_pkg::ST_FIN: begin
        ctrl_o.op = stat_i.out_free ? sddc_pkg::OP_FIN : sddc_pkg::OP_NONE;
      end
      default: ctrl_o.op = sddc_pkg::OP_NONE;
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_to_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> (state_q == sddc_pkg::ST_CMD))
    else $error("accepted request did not start command decode");

  a_fin_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.op == sddc_pkg::OP_FIN) |=> req_ready_o)
    else $error("controller not ready after result was issued");

  a_no_op_while_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_o |-> (ctrl_o.op == sddc_pkg::OP_NONE))
    else $error("datapath step issued while accepting a request");
`endif

endmodule

// ===== design/sddc_dp.sv =====
`timescale 1ns / 1ps
// Datapath: held date, year estimate, days-before-year unit, year and month walk,
// and the result register. Depends on sddc_pkg and sddc_res_if.
module sddc_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sddc_pkg::sddc_req_t  req_i,
  input  sddc_pkg::sddc_ctrl_t ctrl_i,
  output sddc_pkg::sddc_stat_t stat_o,
  sddc_res_if.source           res_o
);

  localparam int unsigned YearW   = sddc_pkg::YearW;
  localparam int unsigned SerialW = sddc_pkg::SerialW;
  localparam int unsigned DayW    = sddc_pkg::DayW;
  localparam int unsigned MonthW  = sddc_pkg::MonthW;
  localparam int unsigned DoyW    = sddc_pkg::DoyW;
  localparam int unsigned DowW    = sddc_pkg::DowW;

  // Latched request
  sddc_pkg::sddc_cmd_e        cmd_q;
  logic [DayW-1:0]            day_in_q;
  logic [MonthW-1:0]          month_in_q;
  logic [sddc_pkg::CountW-1:0] cnt_q;

  // Work registers
  logic [YearW-1:0]   y_q;
  logic [SerialW-1:0] n_q;
  logic               leap_q;
  logic [7:0]         q100_q;
  logic [SerialW-1:0] span_q;
  logic [SerialW-1:0] dby_q;
  logic [DoyW-1:0]    x_q;
  logic [MonthW-1:0]  m_q;

  // Held date
  logic [SerialW-1:0] held_serial_q;
  logic [DayW-1:0]    held_day_q;
  logic [MonthW-1:0]  held_month_q;
  logic [YearW-1:0]   held_year_q;
  logic               held_leap_q;

  // Result register
  logic               out_valid_q;
  logic               res_valid_q;
  logic [DayW-1:0]    res_day_q;
  logic [MonthW-1:0]  res_month_q;
  logic [YearW-1:0]   res_year_q;
  logic [SerialW-1:0] res_serial_q;
  logic [DowW-1:0]    res_dow_q;
  logic               res_leap_q;

  logic               held_ok;
  logic [SerialW:0]   sum_ext;
  logic               add_ok;
  logic               sub_ok;
  logic               is_add;
  logic               is_sub;
  logic [SerialW-1:0] n_next;
  logic [23:0]        est_num;
  logic [47:0]        est_prod;
  logic [YearW-1:0]   ym1;
  logic [26:0]        hund_prod;
  logic [22:0]        span_full;
  logic [SerialW-1:0] dby_calc;
  logic [DoyW-1:0]    year_len;
  logic [SerialW:0]   next_dby;
  logic [DayW-1:0]    cur_dim;
  logic [DayW-1:0]    load_dim;
  logic               load_ok;
  logic [SerialW-1:0] load_serial;

  assign held_ok = (held_serial_q != '0);
  assign is_add  = (cmd_q == sddc_pkg::CMD_ADD);
  assign is_sub  = (cmd_q == sddc_pkg::CMD_SUB);
  assign sum_ext = {1'b0, held_serial_q} + {1'b0, cnt_q};
  assign add_ok  = (sum_ext <= (SerialW + 1)'(sddc_pkg::LastSerial));
  assign sub_ok  = (cnt_q < held_serial_q);
  assign n_next  = is_add ? sum_ext[SerialW-1:0] : held_serial_q - cnt_q;

  // Year estimate 1901 + floor(4*(n-1)/1461), never past the true year
  assign est_num  = {n_q - SerialW'(1), 2'b00};
  assign est_prod = 48'(est_num) * 48'(sddc_pkg::RecipYearMul);

  // Days before year y = 365*(y-1901) + leaps(y-1) - leaps(1900)
  assign ym1       = y_q - YearW'(1);
  assign hund_prod = 27'(ym1) * 27'(sddc_pkg::RecipHundred);
  assign span_full = 23'(y_q - YearW'(sddc_pkg::FirstYear)) * 23'(365);
  assign dby_calc  = span_q + SerialW'(ym1 >> 2) - SerialW'(q100_q)
                     + SerialW'(q100_q >> 2) - SerialW'(sddc_pkg::LeapsTo1900);

  assign year_len = DoyW'(365) + DoyW'(leap_q);
  assign next_dby = {1'b0, dby_q} + (SerialW + 1)'(year_len);
  assign cur_dim  = sddc_pkg::month_days(m_q, leap_q);
  assign load_dim = sddc_pkg::month_days(month_in_q, leap_q);

  assign load_ok = (month_in_q >= MonthW'(1)) && (month_in_q <= MonthW'(12))
                   && (y_q >= YearW'(sddc_pkg::FirstYear))
                   && (y_q <= YearW'(sddc_pkg::LastYear))
                   && (day_in_q != '0) && (day_in_q <= load_dim);
  assign load_serial = dby_q + SerialW'(sddc_pkg::days_before_month(month_in_q))
                       + SerialW'(leap_q && (month_in_q > MonthW'(2)))
                       + SerialW'(day_in_q);

  assign stat_o.go_load  = (cmd_q == sddc_pkg::CMD_LOAD);
  assign stat_o.go_walk  = held_ok && ((is_add && add_ok) || (is_sub && sub_ok));
  assign stat_o.ystep    = (y_q < YearW'(sddc_pkg::LastYear))
                           && (next_dby < {1'b0, n_q});
  assign stat_o.mstep    = (m_q < MonthW'(12)) && (x_q > DoyW'(cur_dim));
  assign stat_o.out_free = !out_valid_q || res_o.ready;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      cmd_q      <= sddc_pkg::sddc_cmd_e'(req_i.command);
      day_in_q   <= req_i.load_day;
      month_in_q <= req_i.load_month;
      cnt_q      <= req_i.day_count;
      y_q        <= req_i.load_year;
    end else begin
      unique case (ctrl_i.op)
        sddc_pkg::OP_CMD:  n_q <= n_next;
        sddc_pkg::OP_EST:  y_q <= YearW'(sddc_pkg::FirstYear)
                                  + est_prod[47:sddc_pkg::RecipYearShift];
        sddc_pkg::OP_LEAP: leap_q <= sddc_pkg::is_leap(y_q);
        sddc_pkg::OP_DBY_A: begin
          q100_q <= hund_prod[26:sddc_pkg::RecipHundredShift];
          span_q <= span_full[SerialW-1:0];
        end
        sddc_pkg::OP_DBY_B: dby_q <= dby_calc;
        sddc_pkg::OP_YSTEP: begin
          if (stat_o.ystep) begin
            y_q   <= y_q + YearW'(1);
            dby_q <= next_dby[SerialW-1:0];
          end
        end
        sddc_pkg::OP_MSTART: begin
          x_q <= DoyW'(n_q - dby_q);
          m_q <= MonthW'(1);
        end
        sddc_pkg::OP_MSTEP: begin
          if (stat_o.mstep) begin
            x_q <= x_q - DoyW'(cur_dim);
            m_q <= m_q + MonthW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_serial_q <= '0;
      held_day_q    <= '0;
      held_month_q  <= '0;
      held_year_q   <= '0;
      held_leap_q   <= 1'b0;
    end else begin
      case (ctrl_i.op)
        sddc_pkg::OP_CMD: begin
          // drop the date on overflow or underflow
          if (held_ok && !stat_o.go_walk && (is_add || is_sub)) begin
            held_serial_q <= '0;
            held_day_q    <= '0;
            held_month_q  <= '0;
            held_year_q   <= '0;
            held_leap_q   <= 1'b0;
          end
        end
        sddc_pkg::OP_MSTEP: begin
          if (!stat_o.mstep) begin
            held_serial_q <= n_q;
            held_day_q    <= x_q[DayW-1:0];
            held_month_q  <= m_q;
            held_year_q   <= y_q;
            held_leap_q   <= leap_q;
          end
        end
        sddc_pkg::OP_LOAD: begin
          if (load_ok) begin
            held_serial_q <= load_serial;
            held_day_q    <= day_in_q;
            held_month_q  <= month_in_q;
            held_year_q   <= y_q;
            held_leap_q   <= leap_q;
          end else begin
            held_serial_q <= '0;
            held_day_q    <= '0;
            held_month_q  <= '0;
            held_year_q   <= '0;
            held_leap_q   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.op == sddc_pkg::OP_FIN) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == sddc_pkg::OP_FIN) begin
      res_valid_q  <= held_ok;
      res_day_q    <= held_day_q;
      res_month_q  <= held_month_q;
      res_year_q   <= held_year_q;
      res_serial_q <= held_serial_q;
      res_dow_q    <= held_ok ? sddc_pkg::weekday_of(held_serial_q) : '0;
      res_leap_q   <= held_leap_q;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.valid_res    = res_valid_q;
  assign res_o.day_of_month = res_day_q;
  assign res_o.month_number = res_month_q;
  assign res_o.year_number  = res_year_q;
  assign res_o.serial_day   = res_serial_q;
  assign res_o.weekday      = res_dow_q;
  assign res_o.leap         = res_leap_q;

`ifndef ASSERT_OFF
  a_held_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_serial_q <= SerialW'(sddc_pkg::LastSerial))
    else $error("held serial number past the last supported day");

  a_held_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_ok |-> ((held_month_q >= MonthW'(1)) && (held_month_q <= MonthW'(12))
                 && (held_day_q != '0)))
    else $error("valid held date has a bad day or month");

  a_weekday_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_valid_q) |-> (res_dow_q != '0))
    else $error("valid result without a weekday");
`endif

endmodule

// ===== design/serial_day_date_calculator.sv =====
`timescale 1ns / 1ps
// Serial day date calculator: controller plus datapath, one request at a time.
// A no-op, or an add or subtract on an invalid or out-of-range date, goes from decode
// to the result; a load first finds the leap flag and days before the year; an add or
// subtract also runs the year estimate, at most one year correction and the month walk.
// A new request is taken in the cycle after the result is issued; the result register
// lets the next request in while the previous result waits. Reset makes the date invalid.
module serial_day_date_calculator (
  input  logic       clk_i,
  input  logic       rst_ni,
  sddc_req_if.sink   req_i,
  sddc_res_if.source res_o
);

  sddc_pkg::sddc_req_t  req_pl;
  sddc_pkg::sddc_ctrl_t ctrl;
  sddc_pkg::sddc_stat_t stat;
  logic                 req_ready;

  assign req_pl.command    = req_i.command;
  assign req_pl.load_day   = req_i.load_day;
  assign req_pl.load_month = req_i.load_month;
  assign req_pl.load_year  = req_i.load_year;
  assign req_pl.day_count  = req_i.day_count;
  assign req_i.ready       = req_ready;

  sddc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  sddc_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_pl),
    .ctrl_i (ctrl),
    .stat_o (stat),
    .res_o  (res_o)
  );

endmodule
